// ===== design/ritt_pkg.sv =====
// Shared types and constants for the radix integer-to-text converter.
package ritt_pkg;

    localparam int CHAR_W     = 8;
    localparam int NUM_CHARS  = 16;
    localparam int CHAR_IDX_W = 4;
    localparam int RADIX_W    = 5;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;

    // Quotient bits resolved by the divider in one cycle.
    localparam int DIV_STEP = 8;

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;
    localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HI = 2'd2;

    typedef logic [NUM_CHARS-1:0][CHAR_W-1:0] t_char_tab;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SIGN,
        S_EMIT
    } t_state;

endpackage

// ===== design/ritt_cfg.sv =====
// Configuration registers and the registered check of the digit alphabet.
module ritt_cfg #(
    parameter int MAX_RADIX = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ritt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ritt_pkg::CFG_W-1:0]          i_cfg_data,
    output logic [ritt_pkg::RADIX_W-1:0]        o_radix,
    output ritt_pkg::t_char_tab                 o_chars,
    output logic                                o_base_ok
);

    logic [ritt_pkg::RADIX_W-1:0] r_radix;
    logic [ritt_pkg::CFG_W-1:0]   r_chars_lo;
    logic [ritt_pkg::CFG_W-1:0]   r_chars_hi;
    logic                         r_base_ok;
    logic                         n_base_ok;
    ritt_pkg::t_char_tab          chars;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= '0;
            r_chars_lo <= '0;
            r_chars_hi <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ritt_pkg::CFG_RADIX:    r_radix    <= i_cfg_data[ritt_pkg::RADIX_W-1:0];
                ritt_pkg::CFG_CHARS_LO: r_chars_lo <= i_cfg_data;
                ritt_pkg::CFG_CHARS_HI: r_chars_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign chars = {r_chars_hi, r_chars_lo};

    // Every pair of digits in use is compared at once; the result is registered
    // because the alphabet is to change only while the block is idle; the block itself does not enforce this.
    always_comb begin
        logic ok;
        ok = (r_radix >= ritt_pkg::RADIX_W'(2)) && (r_radix <= ritt_pkg::RADIX_W'(MAX_RADIX));
        for (int i = 0; i < ritt_pkg::NUM_CHARS; i++) begin
            if (ritt_pkg::RADIX_W'(i) < r_radix) begin
                if (chars[i] == ritt_pkg::NUL_CHAR || chars[i] == ritt_pkg::MINUS_CHAR ||
                    chars[i] == ritt_pkg::PLUS_CHAR) begin
                    ok = 1'b0;
                end
                for (int j = i + 1; j < ritt_pkg::NUM_CHARS; j++) begin
                    if (ritt_pkg::RADIX_W'(j) < r_radix && chars[j] == chars[i]) begin
                        ok = 1'b0;
                    end
                end
            end
        end
        n_base_ok = ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_ok <= 1'b0;
        end else begin
            r_base_ok <= n_base_ok;
        end
    end

    assign o_radix   = r_radix;
    assign o_chars   = chars;
    assign o_base_ok = r_base_ok;

endmodule

// ===== design/ritt_div.sv =====
// Iterative restoring divider by the radix, several quotient bits per cycle.
module ritt_div #(
    parameter int VALUE_BITS = 32,
    parameter int DIGIT_W    = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [VALUE_BITS-1:0]         i_dividend,
    input  logic [ritt_pkg::RADIX_W-1:0]  i_radix,
    output logic                          o_done,
    output logic [VALUE_BITS-1:0]         o_quot,
    output logic [DIGIT_W-1:0]            o_rem
);

    localparam int NCHUNK = (VALUE_BITS + ritt_pkg::DIV_STEP - 1) / ritt_pkg::DIV_STEP;
    localparam int DB     = NCHUNK * ritt_pkg::DIV_STEP;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    logic [DB-1:0]      r_work;
    logic [DB-1:0]      n_work;
    logic [DIGIT_W-1:0] r_rem;
    logic [DIGIT_W-1:0] n_rem;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic               r_done;

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    always_comb begin
        logic [DIGIT_W:0]   part;
        logic               qbit;
        logic [DB-1:0]      work;
        logic [DIGIT_W-1:0] rem;
        work = r_work;
        rem  = r_rem;
        for (int k = 0; k < ritt_pkg::DIV_STEP; k++) begin
            part = {rem, work[DB-1]};
            qbit = (ritt_pkg::RADIX_W'(part) >= i_radix);
            if (qbit) begin
                rem = DIGIT_W'(part - (DIGIT_W + 1)'(i_radix));
            end else begin
                rem = part[DIGIT_W-1:0];
            end
            work = {work[DB-2:0], qbit};
        end
        n_work = work;
        n_rem  = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(NCHUNK - 1));
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NCHUNK - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= DB'(i_dividend);
            r_rem  <= '0;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_work[VALUE_BITS-1:0];
    assign o_rem  = r_rem;

endmodule

// ===== design/ritt_stack.sv =====
// Digit memory: digits are written least significant first and read back in reverse.
module ritt_stack #(
    parameter int DEPTH   = 32,
    parameter int AW      = 5,
    parameter int DIGIT_W = 4
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [DIGIT_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [AW-1:0]      i_raddr,
    output logic [DIGIT_W-1:0] o_rdata
);

    logic [DIGIT_W-1:0] mem [DEPTH];
    logic [DIGIT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/radix_integer_to_text.sv =====
// Top level: sequencer that converts one signed value into radix text characters.
//
//   Channel   Direction  Handshake                     Payload
//   input     in         i_in_valid / o_in_ready       i_value
//   output    out        o_out_valid / i_out_ready     o_text_char, o_last_char
//   config    in         i_cfg_we (no wait)            i_cfg_idx, i_cfg_data
//
// A value takes as long with or without a minus sign. The shared divider resolves 8
// quotient bits a cycle and hands each remainder digit over to the digit memory; the
// characters then leave at one per cycle while the output is ready. A value rejected
// by the alphabet check gives no characters. Reset is synchronous and clears control
// state only. A stalled output holds the sequencer; the next value is taken once the last
// character is loaded into the output register.
module radix_integer_to_text #(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [VALUE_BITS-1:0]       i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [ritt_pkg::CHAR_W-1:0]        o_text_char,
    output logic                               o_last_char,
    input  logic                               i_cfg_we,
    input  logic [ritt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ritt_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int DIGIT_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
    localparam int AW      = $clog2(VALUE_BITS);
    localparam int CNTW    = $clog2(VALUE_BITS + 1);

    ritt_pkg::t_state             r_state;
    ritt_pkg::t_state             n_state;
    logic [VALUE_BITS-1:0]        r_value;
    logic                         r_neg;
    logic                         n_neg;
    logic [CNTW-1:0]              r_cnt;
    logic [CNTW-1:0]              n_cnt;
    logic [CNTW-1:0]              cnt_dec;
    logic                         r_out_valid;
    logic [ritt_pkg::CHAR_W-1:0]  r_out_char;
    logic                         r_out_last;

    logic [ritt_pkg::RADIX_W-1:0] radix;
    ritt_pkg::t_char_tab          chars;
    logic                         base_ok;

    logic                         div_start;
    logic [VALUE_BITS-1:0]        div_dividend;
    logic                         div_done;
    logic [VALUE_BITS-1:0]        div_quot;
    logic [DIGIT_W-1:0]           div_rem;

    logic                         push_we;
    logic                         rd_en;
    logic [DIGIT_W-1:0]           rd_digit;

    logic                         out_free;
    logic                         out_load;
    logic [ritt_pkg::CHAR_W-1:0]  out_char;
    logic                         out_last;
    logic [VALUE_BITS-1:0]        mag;

    ritt_cfg #(
        .MAX_RADIX (MAX_RADIX)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_radix    (radix),
        .o_chars    (chars),
        .o_base_ok  (base_ok)
    );

    ritt_div #(
        .VALUE_BITS (VALUE_BITS),
        .DIGIT_W    (DIGIT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_radix    (radix),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    ritt_stack #(
        .DEPTH   (VALUE_BITS),
        .AW      (AW),
        .DIGIT_W (DIGIT_W)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (push_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (div_rem),
        .i_re    (rd_en),
        .i_raddr (cnt_dec[AW-1:0]),
        .o_rdata (rd_digit)
    );

    // Unsigned magnitude, so the most negative value converts correctly.
    assign mag      = r_value[VALUE_BITS-1] ? (~r_value + 1'b1) : r_value;
    assign cnt_dec  = r_cnt - 1'b1;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_neg        = r_neg;
        n_cnt        = r_cnt;
        div_start    = 1'b0;
        div_dividend = mag;
        push_we      = 1'b0;
        rd_en        = 1'b0;
        out_load     = 1'b0;
        out_char     = ritt_pkg::MINUS_CHAR;
        out_last     = 1'b0;
        unique case (r_state)
            ritt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ritt_pkg::S_CHECK;
                end
            end
            ritt_pkg::S_CHECK: begin
                if (!base_ok) begin
                    n_state = ritt_pkg::S_IDLE;
                end else begin
                    n_neg     = r_value[VALUE_BITS-1];
                    n_cnt     = '0;
                    div_start = 1'b1;
                    n_state   = ritt_pkg::S_DIV;
                end
            end
            ritt_pkg::S_DIV: begin
                if (div_done) begin
                    push_we = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    if (div_quot == '0) begin
                        n_state = ritt_pkg::S_SIGN;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = div_quot;
                    end
                end
            end
            ritt_pkg::S_SIGN: begin
                if (!r_neg || out_free) begin
                    out_load = r_neg;
                    rd_en    = 1'b1;
                    n_cnt    = cnt_dec;
                    n_state  = ritt_pkg::S_EMIT;
                end
            end
            ritt_pkg::S_EMIT: begin
                // The next digit is fetched in the same cycle the current one is sent.
                if (out_free) begin
                    out_load = 1'b1;
                    out_char = chars[ritt_pkg::CHAR_IDX_W'(rd_digit)];
                    out_last = (r_cnt == '0);
                    if (r_cnt == '0) begin
                        n_state = ritt_pkg::S_IDLE;
                    end else begin
                        rd_en = 1'b1;
                        n_cnt = cnt_dec;
                    end
                end
            end
            default: begin
                n_state = ritt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ritt_pkg::S_IDLE;
            r_neg       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_neg   <= n_neg;
            r_cnt   <= n_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ritt_pkg::S_IDLE && i_in_valid) begin
            r_value <= i_value;
        end
        if (out_load) begin
            r_out_char <= out_char;
            r_out_last <= out_last;
        end
    end

    assign o_in_ready  = (r_state == ritt_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_text_char = r_out_char;
    assign o_last_char = r_out_last;

endmodule
